// ===== sv/sdtb_pkg.sv =====
// shared types, constants and codes of the depth-tested sprite blitter
package sdtb_pkg;

   // texture tile side, a power of two
   localparam int TILE        = 64;
   localparam int TILE_BITS   = $clog2(TILE);
   localparam int TEX_ENTRIES = TILE * TILE;
   localparam int TEX_AW      = 2 * TILE_BITS;

   // columns that carry a wall depth
   localparam int MAX_COLUMNS = 2048;
   localparam int COL_AW      = $clog2(MAX_COLUMNS);

   // item modes
   localparam logic [1:0] MODE_TEXEL = 2'd0;
   localparam logic [1:0] MODE_DEPTH = 2'd1;
   localparam logic [1:0] MODE_DRAW  = 2'd2;

   // register indexes
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   localparam logic [12:0] RESET_WIDTH  = 13'd640;
   localparam logic [12:0] RESET_HEIGHT = 13'd480;

   typedef struct packed {
      logic [1:0]         mode;
      logic [11:0]        address;
      logic [31:0]        data;
      logic signed [15:0] x_offset;
      logic signed [15:0] y_offset;
      logic [13:0]        sprite_size;
      logic [23:0]        sprite_dist;
      logic [13:0]        column;
      logic [13:0]        row;
   } req_item_type;

   typedef struct packed {
      logic [23:0] pixel_address;
      logic [31:0] color;
   } rsp_item_type;

   // item state carried down the pipeline
   typedef struct packed {
      logic [1:0]  mode;
      logic        keep;
      logic [11:0] address;
      logic [31:0] data;
      logic [23:0] pix_addr;
   } pipe_type;

   // texel coordinate division state
   typedef struct packed {
      logic [13:0]          rem_x;
      logic [13:0]          rem_y;
      logic [13:0]          size;
      logic [TILE_BITS-1:0] q_x;
      logic [TILE_BITS-1:0] q_y;
   } div_type;

endpackage

// ===== sv/sdtb_front.sv =====
// front stages: screen position, bounds, wall depth store and row address
module sdtb_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  sdtb_pkg::req_item_type in_item,
   input  logic [12:0]           width,
   input  logic [12:0]           height,
   output logic                  out_valid,
   output sdtb_pkg::pipe_type    out_pipe,
   output sdtb_pkg::div_type     out_div
);

   logic signed [16:0] sx_in, sy_in;
   logic               inside_in;

   // stage 1
   logic               v1_ff;
   logic [1:0]         mode1_ff;
   logic [11:0]        addr1_ff;
   logic [31:0]        data1_ff;
   logic signed [16:0] sx1_ff, sy1_ff;
   logic               inside1_ff;
   logic [13:0]        size1_ff;
   logic [23:0]        dist1_ff;
   logic [13:0]        col1_ff, row1_ff;

   // stage 2
   logic               sx_ok, sy_ok, keep2_in, wr_depth;
   logic [25:0]        prod_full;
   logic               v2_ff;
   logic [1:0]         mode2_ff;
   logic [11:0]        addr2_ff;
   logic [31:0]        data2_ff;
   logic               keep2_ff;
   logic [11:0]        sx2_ff;
   logic [23:0]        prod2_ff;
   logic [23:0]        dist2_ff;
   logic [23:0]        depth2_ff;
   logic [13:0]        size2_ff, col2_ff, row2_ff;
   logic [23:0]        depth_mem [0:sdtb_pkg::MAX_COLUMNS-1];

   // stage 3
   logic               v3_ff;
   sdtb_pkg::pipe_type pipe3_ff;
   sdtb_pkg::div_type  div3_ff;

   assign sx_in = $signed({in_item.x_offset[15], in_item.x_offset})
                + $signed({3'b000, in_item.column});
   assign sy_in = $signed({in_item.y_offset[15], in_item.y_offset})
                + $signed({3'b000, in_item.row});
   assign inside_in = (in_item.column < in_item.sprite_size)
                   && (in_item.row < in_item.sprite_size);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mode1_ff   <= in_item.mode;
         addr1_ff   <= in_item.address;
         data1_ff   <= in_item.data;
         sx1_ff     <= sx_in;
         sy1_ff     <= sy_in;
         inside1_ff <= inside_in;
         size1_ff   <= in_item.sprite_size;
         dist1_ff   <= in_item.sprite_dist;
         col1_ff    <= in_item.column;
         row1_ff    <= in_item.row;
      end
   end

   assign sx_ok = !sx1_ff[16] && (sx1_ff[15:0] < {3'b000, width})
               && (sx1_ff[15:0] < 16'(sdtb_pkg::MAX_COLUMNS));
   assign sy_ok = !sy1_ff[16] && (sy1_ff[15:0] < {3'b000, height});
   assign keep2_in = (mode1_ff == sdtb_pkg::MODE_DRAW) && inside1_ff && sx_ok && sy_ok;
   assign wr_depth = v1_ff && (mode1_ff == sdtb_pkg::MODE_DEPTH)
                  && ({1'b0, addr1_ff} < 13'(sdtb_pkg::MAX_COLUMNS));
   // row start; an on-screen row fits in 13 bits
   assign prod_full = {13'd0, sy1_ff[12:0]} * {13'd0, width};

   always_ff @(posedge clock) begin
      if (en) begin
         if (wr_depth) begin
            depth_mem[addr1_ff[sdtb_pkg::COL_AW-1:0]] <= data1_ff[23:0];
         end
         depth2_ff <= depth_mem[sx1_ff[sdtb_pkg::COL_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mode2_ff <= mode1_ff;
         addr2_ff <= addr1_ff;
         data2_ff <= data1_ff;
         keep2_ff <= keep2_in;
         sx2_ff   <= sx1_ff[11:0];
         prod2_ff <= prod_full[23:0];
         dist2_ff <= dist1_ff;
         size2_ff <= size1_ff;
         col2_ff  <= col1_ff;
         row2_ff  <= row1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pipe3_ff.mode     <= mode2_ff;
         // a tie with the wall hides the sprite
         pipe3_ff.keep     <= keep2_ff && (depth2_ff > dist2_ff);
         pipe3_ff.address  <= addr2_ff;
         pipe3_ff.data     <= data2_ff;
         pipe3_ff.pix_addr <= prod2_ff + {12'd0, sx2_ff};
         div3_ff.rem_x     <= col2_ff;
         div3_ff.rem_y     <= row2_ff;
         div3_ff.size      <= size2_ff;
         div3_ff.q_x       <= '0;
         div3_ff.q_y       <= '0;
      end
   end

   assign out_valid = v3_ff;
   assign out_pipe  = pipe3_ff;
   assign out_div   = div3_ff;

endmodule

// ===== sv/sdtb_divider.sv =====
// pipelined restoring division: one quotient bit of each texel coordinate per stage
module sdtb_divider (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  sdtb_pkg::pipe_type in_pipe,
   input  sdtb_pkg::div_type  in_div,
   output logic               out_valid,
   output sdtb_pkg::pipe_type out_pipe,
   output sdtb_pkg::div_type  out_div
);

   localparam int NSTAGE = sdtb_pkg::TILE_BITS;

   logic               v_ff [NSTAGE];
   sdtb_pkg::pipe_type p_ff [NSTAGE];
   sdtb_pkg::div_type  d_ff [NSTAGE];

   // remainder stays below size, so doubling fits in 15 bits
   function automatic sdtb_pkg::div_type div_step(input sdtb_pkg::div_type d);
      sdtb_pkg::div_type r;
      logic [14:0]       dx, dy;
      logic              gx, gy;
      r  = d;
      dx = {d.rem_x, 1'b0};
      dy = {d.rem_y, 1'b0};
      gx = dx >= {1'b0, d.size};
      gy = dy >= {1'b0, d.size};
      r.rem_x = gx ? 14'(dx - {1'b0, d.size}) : dx[13:0];
      r.rem_y = gy ? 14'(dy - {1'b0, d.size}) : dy[13:0];
      r.q_x   = {d.q_x[NSTAGE-2:0], gx};
      r.q_y   = {d.q_y[NSTAGE-2:0], gy};
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NSTAGE; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int k = 1; k < NSTAGE; k++) begin
            v_ff[k] <= v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff[0] <= in_pipe;
         d_ff[0] <= div_step(in_div);
         for (int k = 1; k < NSTAGE; k++) begin
            p_ff[k] <= p_ff[k-1];
            d_ff[k] <= div_step(d_ff[k-1]);
         end
      end
   end

   assign out_valid = v_ff[NSTAGE-1];
   assign out_pipe  = p_ff[NSTAGE-1];
   assign out_div   = d_ff[NSTAGE-1];

endmodule

// ===== sv/sdtb_texel.sv =====
// texture store, transparent key and final pixel decision
module sdtb_texel (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  sdtb_pkg::pipe_type     in_pipe,
   input  sdtb_pkg::div_type      in_div,
   output logic                   res_valid,
   output sdtb_pkg::rsp_item_type res_item
);

   logic        wr_tex;
   logic        vt_ff;
   logic        keept_ff;
   logic [23:0] pixt_ff;
   logic [31:0] tex_rd_ff;
   logic [31:0] key_ff;
   logic [31:0] tex_mem [0:sdtb_pkg::TEX_ENTRIES-1];

   assign wr_tex = in_valid && (in_pipe.mode == sdtb_pkg::MODE_TEXEL)
                && ({1'b0, in_pipe.address} < 13'(sdtb_pkg::TEX_ENTRIES));

   // texel 0 also kept in a register as the transparent key
   always_ff @(posedge clock) begin
      if (en) begin
         if (wr_tex) begin
            tex_mem[in_pipe.address[sdtb_pkg::TEX_AW-1:0]] <= in_pipe.data;
            if (in_pipe.address == 12'd0) begin
               key_ff <= in_pipe.data;
            end
         end
         tex_rd_ff <= tex_mem[{in_div.q_y, in_div.q_x}];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vt_ff <= 1'b0;
      end else if (en) begin
         vt_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         keept_ff <= in_pipe.keep;
         pixt_ff  <= in_pipe.pix_addr;
      end
   end

   assign res_valid              = vt_ff && keept_ff && (tex_rd_ff != key_ff);
   assign res_item.pixel_address = pixt_ff;
   assign res_item.color         = tex_rd_ff;

endmodule

// ===== sv/sprite_depth_tested_blit.sv =====
// top level of the depth-tested sprite pixel blitter
//
//  port group  dir  flow control       carries
//  req_*       in   valid / stall      load texel, load column depth, draw pixel
//  rsp_*       out  valid / stall      framebuffer address and color of a drawn pixel
//  csr_*       in   valid / ready      screen width (index 0), screen height (index 1)
//
// one item enters per cycle while req_stall is low; once its item is taken, a drawn
// pixel passes the front stages, the texel coordinate divider, the texture read
// register and the output register; the divider resolves one quotient bit per stage
// loads and draws keep their order because each store is touched at one stage only
// reset clears valid bits and sets the screen size registers to their defaults; stores hold garbage until loaded
// a result waiting on rsp_stall parks in a skid register; req_stall rises only when
// the skid is full, and then the whole pipeline holds for that cycle
module sprite_depth_tested_blit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  sdtb_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output sdtb_pkg::rsp_item_type rsp_item,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_index,
   input  logic [12:0]            csr_data
);

   // screen size registers
   logic [12:0] width_ff, height_ff;

   // pipeline advance, held only while the skid register is occupied
   logic en;
   logic accept;

   // front to divider
   logic               f_valid;
   sdtb_pkg::pipe_type f_pipe;
   sdtb_pkg::div_type  f_div;

   // divider to texel stage
   logic               d_valid;
   sdtb_pkg::pipe_type d_pipe;
   sdtb_pkg::div_type  d_div;

   // finished pixel from the last stage
   logic                   res_valid;
   sdtb_pkg::rsp_item_type res_item;

   // output register and skid
   logic                   out_v_ff, out_v_in;
   sdtb_pkg::rsp_item_type out_item_ff, out_item_in;
   logic                   skid_v_ff, skid_v_in;
   sdtb_pkg::rsp_item_type skid_item_ff, skid_item_in;
   logic                   take;
   logic                   arrive;

   assign en        = !skid_v_ff;
   assign req_stall = skid_v_ff;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // config is to be written by the user only while idle; the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= sdtb_pkg::RESET_WIDTH;
         height_ff <= sdtb_pkg::RESET_HEIGHT;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            sdtb_pkg::REG_WIDTH:  width_ff  <= csr_data;
            sdtb_pkg::REG_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   sdtb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (accept),
      .in_item   (req_item),
      .width     (width_ff),
      .height    (height_ff),
      .out_valid (f_valid),
      .out_pipe  (f_pipe),
      .out_div   (f_div)
   );

   sdtb_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .in_pipe   (f_pipe),
      .in_div    (f_div),
      .out_valid (d_valid),
      .out_pipe  (d_pipe),
      .out_div   (d_div)
   );

   sdtb_texel u_texel (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d_valid),
      .in_pipe   (d_pipe),
      .in_div    (d_div),
      .res_valid (res_valid),
      .res_item  (res_item)
   );

   // a new pixel lands in the output register if it is free or being taken,
   // otherwise in the skid; the skid drains first
   assign take   = out_v_ff && !rsp_stall;
   assign arrive = res_valid && en;

   always_comb begin
      out_v_in     = out_v_ff;
      out_item_in  = out_item_ff;
      skid_v_in    = skid_v_ff;
      skid_item_in = skid_item_ff;
      if (skid_v_ff) begin
         if (take) begin
            out_item_in = skid_item_ff;
            skid_v_in   = 1'b0;
         end
      end else if (arrive) begin
         if (!out_v_ff || take) begin
            out_v_in    = 1'b1;
            out_item_in = res_item;
         end else begin
            skid_v_in    = 1'b1;
            skid_item_in = res_item;
         end
      end else if (take) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_item_ff  <= out_item_in;
      skid_item_ff <= skid_item_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_item  = out_item_ff;

endmodule

// ===== sv/sdtb_checker.sv =====
// port-level checks of the sprite blitter and their binding to the top level
module sdtb_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input sdtb_pkg::req_item_type req_item,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input sdtb_pkg::rsp_item_type rsp_item,
   input logic                   csr_valid,
   input logic                   csr_ready,
   input logic                   csr_index,
   input logic [12:0]            csr_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("stalled result changed or dropped");

   // nothing comes out in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // input is held back only when a result is already waiting
   a_stall_has_rsp: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result pending");

   // back pressure starts only behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("input stall without a stalled result");

   // the skid empties as soon as the result is taken
   a_stall_drains: assert property (@(posedge clock) disable iff (reset)
      req_stall && !rsp_stall |=> !req_stall)
      else $error("input stall held after result taken");

endmodule

bind sprite_depth_tested_blit sdtb_checker u_checker (.*);

// ===== sim/blit_pixel_monitor.sv =====
// pixel monitor: predicts drawn pixels of the sprite blitter and compares its results
`timescale 1ns / 100ps

module blit_pixel_monitor
   import sdtb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  req_item_type req_item,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  rsp_item_type rsp_item,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic         csr_index,
   input  logic [12:0]  csr_data,
   output int           pending,
   output int           fail_count
);

   logic [31:0]  texels [TEX_ENTRIES];
   logic [23:0]  wall_depth [MAX_COLUMNS];
   logic [12:0]  scr_w;
   logic [12:0]  scr_h;
   rsp_item_type expected_pixels [$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   task automatic report_mismatch(input string what);
      fail_count++;
      if (fail_count <= 40) begin
         $display("[%0t] pixel check: %s", $time, what);
      end
   endtask

   // one draw item: returns 1 and the pixel when it gets written
   function automatic bit blit_pixel(input req_item_type it, output rsp_item_type px);
      int          sx;
      int          sy;
      int unsigned tx;
      int unsigned ty;
      int unsigned idx;
      int unsigned addr;
      logic [31:0] texel;
      px = '0;
      if (it.column >= it.sprite_size || it.row >= it.sprite_size) return 1'b0;
      sx = int'($signed(it.x_offset)) + int'(it.column);
      sy = int'($signed(it.y_offset)) + int'(it.row);
      if (sx < 0 || sx >= int'(scr_w)) return 1'b0;
      if (sy < 0 || sy >= int'(scr_h)) return 1'b0;
      // no wall depth kept past the last column
      if (sx >= MAX_COLUMNS) return 1'b0;
      // a tie with the wall hides the sprite
      if (wall_depth[sx] <= it.sprite_dist) return 1'b0;
      ty    = (TILE * it.row) / it.sprite_size;
      tx    = (TILE * it.column) / it.sprite_size;
      idx   = TILE * ty + tx;
      texel = texels[idx];
      // texel 0 is the transparent key
      if (texel == texels[0]) return 1'b0;
      addr  = sy * scr_w + sx;
      px.pixel_address = addr[23:0];
      px.color         = texel;
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      rsp_item_type want;
      rsp_item_type px;
      if (reset) begin
         scr_w = RESET_WIDTH;
         scr_h = RESET_HEIGHT;
         expected_pixels.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch($sformatf("unexpected pixel addr %h color %h",
                  rsp_item.pixel_address, rsp_item.color));
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_item.pixel_address !== want.pixel_address) begin
                  report_mismatch($sformatf("pixel_address %h, expected %h",
                     rsp_item.pixel_address, want.pixel_address));
               end
               if (rsp_item.color !== want.color) begin
                  report_mismatch($sformatf("color %h, expected %h at addr %h",
                     rsp_item.color, want.color, want.pixel_address));
               end
            end
         end
         if (req_valid && !req_stall) begin
            case (req_item.mode)
               MODE_TEXEL: begin
                  texels[req_item.address] = req_item.data;
               end
               MODE_DEPTH: begin
                  if (req_item.address < MAX_COLUMNS) begin
                     wall_depth[req_item.address[COL_AW-1:0]] = req_item.data[23:0];
                  end
               end
               MODE_DRAW: begin
                  if (blit_pixel(req_item, px)) expected_pixels.push_back(px);
               end
               default: ;
            endcase
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_WIDTH:  scr_w = csr_data;
               REG_HEIGHT: scr_h = csr_data;
               default: ;
            endcase
         end
      end
      pending = expected_pixels.size();
   end

endmodule

// ===== sim/tb_top.sv =====
// top of the sprite blitter testbench: stimulus, idling and the final verdict
`timescale 1ns / 100ps

module tb_top;
   import sdtb_pkg::*;

   // mode with no function, only here to send it
   localparam logic [1:0] MODE_SPARE = 2'd3;

   localparam int DRAIN_CYCLES    = 24;     // pipeline depth plus skid, with margin
   localparam int DRAIN_GUARD     = 20000;
   localparam int HOLD_CYCLES     = 300;
   localparam int ITEMS_PER_PHASE = 150;
   localparam int NUM_PHASES      = 8;
   localparam int TIMEOUT_NS      = 4000000;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic         csr_index = REG_WIDTH;
   logic [12:0]  csr_data  = '0;

   int pending_pixels;
   int pixel_failures;

   // screen size as last programmed, used to aim the draws
   int cur_w = RESET_WIDTH;
   int cur_h = RESET_HEIGHT;

   // what the stimulus has loaded, so draws can be aimed at the wall depth
   logic [23:0] depth_loaded [MAX_COLUMNS];
   logic [31:0] key_color;

   // idling control of the sender and the receiver; calm is shared by both
   bit calm    = 1'b0;
   bit hold_go = 1'b0;
   int gap_pct   = 0;
   int stall_pct = 0;
   int sent_count = 0;

   // screen sizes of the random phases, extremes among them
   int phase_w [NUM_PHASES] = '{640, 1, 4096, 8191, 0, 640, 2048, 4096};
   int phase_h [NUM_PHASES] = '{480, 1, 4096, 8191, 480, 0, 64, 1};

   sprite_depth_tested_blit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   blit_pixel_monitor pixel_watch (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .pending    (pending_pixels),
      .fail_count (pixel_failures)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // hard stop if the run hangs
   initial begin
      #(TIMEOUT_NS);
      $display("sprite_depth_tested_blit verification failed");
      $finish;
   end

   // idle share for one stretch: none, light or heavy
   function automatic int pick_idle_pct();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 10;
         default: return 35;
      endcase
   endfunction

   // result side: short random stalls, one long hold-off on request, none when calm
   initial begin
      int cycles;
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles % 64 == 0) stall_pct = pick_idle_pct();
         if (hold_go) begin
            // long hold so the pipeline fills and pushes back on the sender
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_go = 1'b0;
         end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // offer one item and hold it until taken; valid stays up unless a gap follows
   task automatic send(input req_item_type it);
      req_item  <= it;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
      if (sent_count % 64 == 0) gap_pct = pick_idle_pct();
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // stop offering, wait for every expected pixel, then let the pipeline empty
   task automatic wait_drained();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
         guard++;
      end while (pending_pixels != 0 && guard < DRAIN_GUARD);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // both size registers, valid kept high across the two writes
   task automatic set_screen(input int w, input int h);
      csr_index <= REG_WIDTH;
      csr_data  <= w[12:0];
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= REG_HEIGHT;
      csr_data  <= h[12:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cur_w = w;
      cur_h = h;
   endtask

   // item with every field random, so that unused fields toggle too
   function automatic req_item_type blank_item(input logic [1:0] mode);
      req_item_type it;
      it.mode        = mode;
      it.address     = 12'($urandom);
      it.data        = $urandom;
      it.x_offset    = 16'($urandom);
      it.y_offset    = 16'($urandom);
      it.sprite_size = 14'($urandom);
      it.sprite_dist = 24'($urandom);
      it.column      = 14'($urandom);
      it.row         = 14'($urandom);
      return it;
   endfunction

   // texel colors: a good share equal to the transparent key
   function automatic logic [31:0] palette_color();
      if ($urandom_range(0, 3) == 0) return key_color;
      return $urandom;
   endfunction

   function automatic logic [31:0] depth_word();
      logic [31:0] w;
      w = $urandom;
      if ($urandom_range(0, 9) != 0) w[23:0] = 24'($urandom_range(24'h000400, 24'hFFFFFF));
      return w;
   endfunction

   task automatic load_texel(input int addr, input logic [31:0] color);
      req_item_type it;
      it = blank_item(MODE_TEXEL);
      it.address = addr[11:0];
      it.data    = color;
      if (addr == 0) key_color = color;
      send(it);
   endtask

   task automatic load_depth(input int col, input logic [31:0] value);
      req_item_type it;
      it = blank_item(MODE_DEPTH);
      it.address = col[11:0];
      it.data    = value;
      // loads past the last depth column are dropped by the block
      if (col < MAX_COLUMNS) depth_loaded[col] = value[23:0];
      send(it);
   endtask

   task automatic draw(input int xo, input int yo, input int size, input logic [23:0] spr_dist,
                       input int col, input int row);
      req_item_type it;
      it = blank_item(MODE_DRAW);
      it.x_offset    = xo[15:0];
      it.y_offset    = yo[15:0];
      it.sprite_size = size[13:0];
      it.sprite_dist = spr_dist;
      it.column      = col[13:0];
      it.row         = row[13:0];
      send(it);
   endtask

   // screen coordinate to aim at: mostly on screen, some at and past the edges
   function automatic int aim(input int extent, input int cap, output bit aimed);
      int span;
      span  = (extent < cap) ? extent : cap;
      aimed = 1'b1;
      case ($urandom_range(0, 19))
         0: aimed = 1'b0;
         1: return extent;
         2: return -1;
         3: if (span > 0) return span - 1;
         4: return 0;
         5: if (extent > 0) return $urandom_range(0, extent - 1);
         default: if (span > 0) return $urandom_range(0, span - 1);
      endcase
      aimed = 1'b0;
      return 0;
   endfunction

   // draw with a random sprite, mostly well-formed, mostly aimed on screen and mostly in front of the wall
   function automatic req_item_type random_draw();
      req_item_type it;
      int          sz;
      int          cx;
      int          cy;
      int          sx;
      int          sy;
      int          pick;
      bit          x_aimed;
      bit          y_aimed;
      logic [23:0] wall;
      it   = blank_item(MODE_DRAW);
      pick = $urandom_range(0, 99);
      if (pick < 3) sz = 0;
      else if (pick < 80) sz = $urandom_range(1, 64);
      else if (pick < 95) sz = $urandom_range(65, 1024);
      else if (pick < 98) sz = $urandom_range(1025, 16382);
      else sz = 16383;
      it.sprite_size = sz[13:0];
      if (sz > 0 && $urandom_range(0, 9) != 0) begin
         cx = $urandom_range(0, sz - 1);
         cy = $urandom_range(0, sz - 1);
      end else begin
         cx = $urandom_range(0, 16383);
         cy = $urandom_range(0, 16383);
      end
      it.column = cx[13:0];
      it.row    = cy[13:0];
      sx = aim(cur_w, MAX_COLUMNS, x_aimed);
      sy = aim(cur_h, 8192, y_aimed);
      if (x_aimed) it.x_offset = 16'(sx - cx);
      if (y_aimed) it.y_offset = 16'(sy - cy);
      if (x_aimed && sx >= 0 && sx < MAX_COLUMNS) begin
         wall = depth_loaded[sx];
         pick = $urandom_range(0, 99);
         if (pick < 70) it.sprite_dist = (wall == 0) ? 24'd0 : 24'($urandom_range(0, wall - 1));
         else if (pick < 80) it.sprite_dist = wall;
      end
      return it;
   endfunction

   // random mix: mostly draws, some loads that move the stores under them
   function automatic req_item_type random_item();
      req_item_type it;
      int           pick;
      pick = $urandom_range(0, 99);
      if (pick < 72) return random_draw();
      if (pick < 84) begin
         it = blank_item(MODE_TEXEL);
         it.data = palette_color();
         if (it.address == 0) key_color = it.data;
      end else if (pick < 96) begin
         it = blank_item(MODE_DEPTH);
         it.data = depth_word();
         if (it.address < MAX_COLUMNS) depth_loaded[it.address[COL_AW-1:0]] = it.data[23:0];
      end else begin
         it = blank_item(MODE_SPARE);
      end
      return it;
   endfunction

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      gap_pct   = pick_idle_pct();
      stall_pct = pick_idle_pct();

      // reset values written back once, at idle after reset
      set_screen(RESET_WIDTH, RESET_HEIGHT);

      // fill both stores so no draw ever reads an entry never written
      key_color = $urandom;
      load_texel(0, key_color);
      for (int i = 1; i < TEX_ENTRIES; i++) load_texel(i, palette_color());
      for (int i = 0; i < MAX_COLUMNS; i++) load_depth(i, depth_word());

      // directed: fixed texels and walls to aim at
      load_texel(TEX_ENTRIES - 1, 32'hFFFF_FFFF);
      load_texel(2080, 32'h1234_5678);
      load_depth(0, 32'hFF80_0000);         // upper data bits dropped
      load_depth(639, 32'h0080_0000);
      load_depth(5, 32'h0000_1000);
      load_depth(4095, 32'hFFFF_FFFF);      // past the depth store, ignored
      load_depth(MAX_COLUMNS, 32'h0000_0000);
      // last sprite row and column landing on screen column 0, row 0
      draw(-63, -63, 64, 24'd0, 63, 63);
      // bottom right pixel of the screen, then one past the right, bottom and left edges
      draw(638, 478, 2, 24'd0, 1, 1);
      draw(639, 478, 2, 24'd0, 1, 1);
      draw(638, 479, 2, 24'd0, 1, 1);
      draw(-1, 0, 2, 24'd0, 0, 1);
      // pixels at extreme offsets, the first outside the sprite square
      draw(-32768, 32767, 16383, 24'hFFFFFF, 16383, 16383);
      draw(32767, -32768, 1, 24'd0, 0, 0);
      // size zero sprite
      draw(0, 0, 0, 24'd0, 0, 0);
      // wall tie hides, just nearer draws, far behind hides
      draw(4, 4, 2, 24'h001000, 1, 1);
      draw(4, 4, 2, 24'h000FFF, 1, 1);
      draw(4, 4, 2, 24'hFFFFFF, 1, 1);
      // top-left pixel maps to texel 0, the transparent key
      draw(100, 100, 64, 24'd0, 0, 0);
      // largest sprite, last pixel scales to the last texel
      draw(-16372, -16372, 16383, 24'd0, 16382, 16382);
      draw(0, 0, 64, 24'h7FFFFF, 0, 1);
      send(blank_item(MODE_SPARE));

      // random phases, each at its own screen size, programmed at idle
      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_drained();
         set_screen(phase_w[p], phase_h[p]);
         if (p == 0) hold_go = 1'b1;            // long result hold-off while items keep coming
         if (p == NUM_PHASES - 1) calm = 1'b1;  // no idling at the end
         repeat (ITEMS_PER_PHASE) send(random_item());
      end

      wait_drained();
      if (pixel_failures == 0 && pending_pixels == 0) begin
         $display("sprite_depth_tested_blit verification clean");
      end else begin
         if (pending_pixels != 0) $display("%0d expected pixels never came out", pending_pixels);
         $display("sprite_depth_tested_blit verification failed");
      end
      $finish;
   end

endmodule
